// ===== rtl/s2cd_pkg.sv =====
package s2cd_pkg;

  localparam logic [31:0] SECS_PER_DAY   = 32'd86400;
  localparam logic [31:0] SECS_PER_HOUR  = 32'd3600;
  localparam logic [31:0] SECS_PER_MIN   = 32'd60;
  localparam logic [31:0] DAYS_PER_CYCLE = 32'd1461;
  localparam logic [31:0] LEAP_DAYS      = 32'd366;
  localparam logic [31:0] COMMON_DAYS    = 32'd365;
  localparam logic [3:0]  LAST_MONTH     = 4'd11;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_DAY   = 7'b0000010,
    ST_HOUR  = 7'b0000100,
    ST_MIN   = 7'b0001000,
    ST_CYC   = 7'b0010000,
    ST_YEAR  = 7'b0100000,
    ST_MONTH = 7'b1000000
  } state_t;

  function automatic logic [4:0] month_len(input logic leap, input logic [3:0] month);
    logic [4:0] len;
    unique case (month)
      4'd1:                      len = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ===== rtl/seconds_to_calendar_date.sv =====
// Seconds count to calendar date and time of day.
//
// Input word (s_*): 32-bit seconds since the epoch. Output word (m_*): year
// offset, month index, day of month, hour and minute.
// One word is converted at a time. s_tready is high only while the block is
// idle; a word is taken on s_tvalid && s_tready.
// The divisions and the year and month walks go through one 32-bit
// subtract/compare unit, one step per cycle: 16 steps divide by the day
// length, 5 and 6 steps split hour and minute, 6 steps divide the day count
// into four-year cycles, then 1 to 4 year steps and 1 to 12 month steps.
// A new word can be accepted in the cycle after the result is loaded into
// the output register.
// The output register holds the result while m_tready is low; the next
// result waits in the last step until the register is free.
// rst (synchronous) returns the sequencer to idle and drops m_tvalid.
module seconds_to_calendar_date (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] seconds_count
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // [7:0] year_offset, [11:8] month_index,
                                 // [16:12] day_of_month, [21:17] hour,
                                 // [27:22] minute, [31:28] zero
);
  import s2cd_pkg::*;

  state_t      state;
  logic [31:0] acc;
  logic [3:0]  step;
  logic [15:0] days;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [7:0]  year;
  logic [3:0]  month;

  logic [31:0] opnd;
  logic [32:0] diff;
  logic        ge;
  logic        leap;
  logic        out_free;
  logic        load;

  assign leap     = (year[1:0] == 2'd0);
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE) && !rst;
  assign load     = (state == ST_MONTH) && !(ge && month != LAST_MONTH) && out_free;

  always_comb begin
    unique case (state)
      ST_DAY:   opnd = SECS_PER_DAY << step;
      ST_HOUR:  opnd = SECS_PER_HOUR << step;
      ST_MIN:   opnd = SECS_PER_MIN << step;
      ST_CYC:   opnd = DAYS_PER_CYCLE << step;
      ST_YEAR:  opnd = leap ? LEAP_DAYS : COMMON_DAYS;
      ST_MONTH: opnd = {27'd0, month_len(leap, month)};
      default:  opnd = '0;
    endcase
  end

  // shared subtract/compare unit
  assign diff = {1'b0, acc} - {1'b0, opnd};
  assign ge   = !diff[32];

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            acc   <= s_tdata;
            step  <= 4'd15;
            year  <= '0;
            state <= ST_DAY;
          end
        end
        ST_DAY: begin
          days <= {days[14:0], ge};
          acc  <= ge ? diff[31:0] : acc;
          if (step == 4'd0) begin
            step  <= 4'd4;
            state <= ST_HOUR;
          end else begin
            step <= step - 4'd1;
          end
        end
        ST_HOUR: begin
          hour <= {hour[3:0], ge};
          acc  <= ge ? diff[31:0] : acc;
          if (step == 4'd0) begin
            step  <= 4'd5;
            state <= ST_MIN;
          end else begin
            step <= step - 4'd1;
          end
        end
        ST_MIN: begin
          minute <= {minute[4:0], ge};
          if (step == 4'd0) begin
            acc   <= {16'd0, days};
            step  <= 4'd5;
            state <= ST_CYC;
          end else begin
            acc  <= ge ? diff[31:0] : acc;
            step <= step - 4'd1;
          end
        end
        ST_CYC: begin
          acc <= ge ? diff[31:0] : acc;
          if (step == 4'd0) begin
            year  <= {year[4:0], ge, 2'b00};
            month <= '0;
            state <= ST_YEAR;
          end else begin
            year <= {year[6:0], ge};
            step <= step - 4'd1;
          end
        end
        ST_YEAR: begin
          if (ge) begin
            acc  <= diff[31:0];
            year <= year + 8'd1;
          end else begin
            state <= ST_MONTH;
          end
        end
        ST_MONTH: begin
          if (ge && month != LAST_MONTH) begin
            acc   <= diff[31:0];
            month <= month + 4'd1;
          end else if (out_free) begin
            m_tdata <= {4'd0, minute, hour, acc[4:0] + 5'd1, month, year};
            state   <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_hour_rem: assert property (@(posedge clk) disable iff (rst)
    (state == ST_HOUR) |-> (acc < SECS_PER_DAY))
    else $error("remainder after day division out of range");

  a_year_rem: assert property (@(posedge clk) disable iff (rst)
    (state == ST_YEAR) |-> (acc < DAYS_PER_CYCLE))
    else $error("day count after cycle division out of range");

  a_month_rng: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MONTH) |-> (month <= LAST_MONTH && acc < LEAP_DAYS))
    else $error("month walk out of range");

  a_out_rng: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[21:17] < 5'd24 && m_tdata[27:22] < 6'd60 &&
                  m_tdata[16:12] != 5'd0 && m_tdata[7:0] <= 8'd136))
    else $error("result field out of range");

  a_load: assert property (@(posedge clk) disable iff (rst)
    load |=> m_tvalid)
    else $error("finished result not presented");
`endif

endmodule
